@@ design/fqr_pkg.sv @@
// ---------------------------------------------------------------------------
// fqr_pkg
// Shared types and constants for the queue with remove by value.
// ---------------------------------------------------------------------------
package fqr_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;
  localparam int OCC_BITS      = 5;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic [FIELD_BITS-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] result_value;
    logic                  success;
    logic [FIELD_BITS-1:0] head_value;
    logic [FIELD_BITS-1:0] tail_value;
    logic [OCC_BITS-1:0]   occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_REPORT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic update;
  } dp_cmd_t;

endpackage

@@ design/fqr_ctrl.sv @@
// ---------------------------------------------------------------------------
// fqr_ctrl
// Sequencer: takes a beat, runs the update step, then holds the result beat.
// ---------------------------------------------------------------------------
module fqr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output fqr_pkg::dp_cmd_t cmd
);
  import fqr_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.update = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_REPORT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/fqr_datapath.sv @@
// ---------------------------------------------------------------------------
// fqr_datapath
// Row of entry cells with per-cell compare and gap-closing shift.
// ---------------------------------------------------------------------------
module fqr_datapath #(
  parameter int DEPTH     = fqr_pkg::DEPTH_DEF,
  parameter int WORD_BITS = fqr_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fqr_pkg::dp_cmd_t  cmd,
  input  fqr_pkg::in_item_t in_data,
  output fqr_pkg::out_item_t out_data
);
  import fqr_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [WORD_BITS-1:0] cell_r   [DEPTH];
  logic [WORD_BITS-1:0] cell_nxt [DEPTH];
  logic [CNT_W-1:0]     count_r, count_nxt;
  op_t                  op_r;
  logic [WORD_BITS-1:0] elem_r;
  logic [DEPTH-1:0]     match_r, match_nxt;
  logic [WORD_BITS-1:0] result_r, result_nxt;
  logic                 success_r, success_nxt;

  logic [WORD_BITS+FIELD_BITS-1:0] elem_wide;
  logic [WORD_BITS-1:0]            elem_w;
  logic [DEPTH-1:0]                prefix;
  logic                            hit;
  logic                            not_empty;
  logic                            not_full;
  logic [CNT_W-1:0]                last_pos;
  logic [WORD_BITS-1:0]            head_w, tail_w;
  logic [WORD_BITS+FIELD_BITS-1:0] result_wide, head_wide, tail_wide;
  logic [CNT_W+OCC_BITS-1:0]       occ_wide;

  assign elem_wide = {{WORD_BITS{1'b0}}, in_data.element};
  assign elem_w    = elem_wide[WORD_BITS-1:0];
  assign not_empty = (count_r != '0);
  assign not_full  = (count_r < CNT_W'(DEPTH));

  // compare against the incoming value while the beat is taken
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (cell_r[i] == elem_w) && (CNT_W'(i) < count_r);
    end
  end

  // cells at or after the first match move toward the head
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prefix[i] = |(match_r & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
    end
  end
  assign hit = |match_r;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    count_nxt   = count_r;
    result_nxt  = '0;
    success_nxt = 1'b0;
    unique case (op_r)
      OP_ENQUEUE: begin
        if (not_full) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == count_r) cell_nxt[i] = elem_r;
          end
          count_nxt   = count_r + CNT_W'(1);
          success_nxt = 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (not_empty) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            cell_nxt[i] = cell_r[i+1];
          end
          count_nxt   = count_r - CNT_W'(1);
          result_nxt  = cell_r[0];
          success_nxt = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (prefix[i]) cell_nxt[i] = cell_r[i+1];
          end
          count_nxt   = count_r - CNT_W'(1);
          result_nxt  = elem_r;
          success_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt   = '0;
        success_nxt = 1'b1;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.operation;
      elem_r  <= elem_w;
      match_r <= match_nxt;
    end
    if (cmd.update) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
      result_r  <= result_nxt;
      success_r <= success_nxt;
    end
  end

  assign last_pos = count_r - CNT_W'(1);
  assign head_w   = not_empty ? cell_r[0] : '0;
  assign tail_w   = not_empty ? cell_r[last_pos[IDX_W-1:0]] : '0;

  assign result_wide = {{FIELD_BITS{1'b0}}, result_r};
  assign head_wide   = {{FIELD_BITS{1'b0}}, head_w};
  assign tail_wide   = {{FIELD_BITS{1'b0}}, tail_w};
  assign occ_wide    = {{OCC_BITS{1'b0}}, count_r};

  assign out_data.result_value = result_wide[FIELD_BITS-1:0];
  assign out_data.success      = success_r;
  assign out_data.head_value   = head_wide[FIELD_BITS-1:0];
  assign out_data.tail_value   = tail_wide[FIELD_BITS-1:0];
  assign out_data.occupancy    = occ_wide[OCC_BITS-1:0];

endmodule

@@ design/fifo_queue_with_remove_by_value.sv @@
// ---------------------------------------------------------------------------
// fifo_queue_with_remove_by_value
// Order-keeping queue with enqueue, dequeue, remove-first-equal and clear.
// ---------------------------------------------------------------------------
// result beat: presented in the report state, which follows the update state
//   after the input beat is taken; a new beat is taken only when idle, once
//   the last result beat is accepted; all cells compare at take, shift on update
// reset: synchronous active-low rst_n empties the queue; cell contents
//   are not cleared, they are only read below the occupancy
module fifo_queue_with_remove_by_value #(
  parameter int DEPTH     = fqr_pkg::DEPTH_DEF,
  parameter int WORD_BITS = fqr_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fqr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fqr_pkg::out_item_t out_data
);
  import fqr_pkg::*;

  dp_cmd_t cmd;

  fqr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fqr_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ design/fqr_checker.sv @@
// ---------------------------------------------------------------------------
// fqr_checker
// Port-level checks for the queue, bound to the top level.
// ---------------------------------------------------------------------------
module fqr_checker #(
  parameter int DEPTH = fqr_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fqr_pkg::out_item_t out_data
);
  import fqr_pkg::*;

  logic [31:0] occ_ext;

  assign occ_ext = {27'd0, out_data.occupancy};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result beat is pending");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result beat not presented two cycles after input beat");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (DEPTH < 32)) |-> (occ_ext <= 32'(DEPTH)))
    else $error("occupancy above depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.occupancy == '0) && (DEPTH < 32)) |->
      ((out_data.head_value == '0) && (out_data.tail_value == '0)))
    else $error("head or tail nonzero on empty queue");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind fifo_queue_with_remove_by_value fqr_checker #(.DEPTH(DEPTH)) u_fqr_checker (.*);
